// ===== rtl/bdlpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlpc_pkg
// Shared widths, reset values and register indexes for the pushbutton
// debouncer with long-press detection and edge counter.
// ----------------------------------------------------------------------------
package bdlpc_pkg;

	localparam int SET_W        = 16;
	localparam int MODE_W       = 2;
	localparam int EDGE_COUNT_W = 16;
	localparam int CFG_INDEX_W  = 8;
	localparam int CFG_DATA_W   = 16;

	localparam int TIMER_BITS_DEFAULT = 16;
	localparam int COUNT_BITS_DEFAULT = 16;

	localparam logic [SET_W-1:0]  DEBOUNCE_RESET   = 16'd50;
	localparam logic [SET_W-1:0]  LONG_PRESS_RESET = 16'd2000;
	localparam logic [MODE_W-1:0] COUNT_MODE_RESET = 2'd0;
	localparam logic              ACTIVE_HIGH_RESET = 1'b0;

	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_MODE       = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH      = 8'd3;

	localparam int MODE_FALLING_BIT = 0;
	localparam int MODE_RISING_BIT  = 1;

endpackage

// ===== rtl/button_debounce_longpress_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_longpress_counter
// Debounces a sampled pushbutton level, reports pressed and released events,
// counts steady edges and flags long presses.
// ----------------------------------------------------------------------------
// Each input beat is one sample tick of the raw pin level and yields exactly
// one result beat. The whole update is a single pass of small compares and
// counters into the state and result registers, so a beat is accepted in
// every cycle and its result appears in the next cycle; the result register is
// the only buffer, so input is held off only while a result waits to be taken.
// Configuration writes are always ready and are meant to be issued while the
// block is idle; writing the active level reloads the raw and steady levels
// with the new unpressed level.
module button_debounce_longpress_counter #(
	parameter int TIMER_BITS = bdlpc_pkg::TIMER_BITS_DEFAULT,
	parameter int COUNT_BITS = bdlpc_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  pin_level,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  pressed_event,
	output logic                                  released_event,
	output logic                                  long_press_flag,
	output logic [bdlpc_pkg::EDGE_COUNT_W-1:0]    edge_count,
	output logic                                  stable_level,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bdlpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bdlpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CMP_W = (TIMER_BITS > bdlpc_pkg::SET_W) ? TIMER_BITS : bdlpc_pkg::SET_W;

	logic [bdlpc_pkg::SET_W-1:0]  debounce_ticks_q;
	logic [bdlpc_pkg::SET_W-1:0]  long_press_ticks_q;
	logic [bdlpc_pkg::MODE_W-1:0] count_mode_q;
	logic                         active_high_q;

	logic                  raw_last_q;
	logic [TIMER_BITS-1:0] quiet_timer_q;
	logic                  steady_q;
	logic [TIMER_BITS-1:0] hold_timer_q;
	logic                  long_press_q;
	logic [COUNT_BITS-1:0] edge_counter_q;

	logic                                out_valid_q;
	logic                                pressed_q;
	logic                                released_q;
	logic                                long_press_out_q;
	logic [bdlpc_pkg::EDGE_COUNT_W-1:0]  edge_count_q;
	logic                                stable_q;

	logic                  in_fire;
	logic                  quiet_next;
	logic [TIMER_BITS-1:0] quiet_timer_d;
	logic [TIMER_BITS-1:0] hold_inc;
	logic [TIMER_BITS-1:0] hold_timer_d;
	logic                  steady_d;
	logic                  changed;
	logic                  pressed_d;
	logic                  released_d;
	logic                  long_press_d;
	logic                  count_en;
	logic [COUNT_BITS-1:0] edge_counter_d;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		quiet_next = (pin_level == raw_last_q);
		if (!quiet_next) begin
			quiet_timer_d = '0;
		end else if (quiet_timer_q == {TIMER_BITS{1'b1}}) begin
			quiet_timer_d = quiet_timer_q;
		end else begin
			quiet_timer_d = quiet_timer_q + 1'b1;
		end

		if (hold_timer_q == {TIMER_BITS{1'b1}}) begin
			hold_inc = hold_timer_q;
		end else begin
			hold_inc = hold_timer_q + 1'b1;
		end

		if (CMP_W'(quiet_timer_d) > CMP_W'(debounce_ticks_q)) begin
			steady_d = pin_level;
		end else begin
			steady_d = steady_q;
		end

		changed      = (steady_d != steady_q);
		pressed_d    = changed && (steady_d == active_high_q);
		released_d   = changed && (steady_d != active_high_q);
		hold_timer_d = hold_inc;
		long_press_d = long_press_q;
		count_en     = 1'b0;
		if (changed) begin
			if (!steady_d) begin
				hold_timer_d = '0;
				long_press_d = 1'b0;
				count_en     = count_mode_q[bdlpc_pkg::MODE_FALLING_BIT];
			end else begin
				if (CMP_W'(hold_inc) > CMP_W'(long_press_ticks_q)) begin
					long_press_d = 1'b1;
				end
				count_en = count_mode_q[bdlpc_pkg::MODE_RISING_BIT];
			end
		end
		edge_counter_d = count_en ? edge_counter_q + 1'b1 : edge_counter_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= bdlpc_pkg::DEBOUNCE_RESET;
			long_press_ticks_q <= bdlpc_pkg::LONG_PRESS_RESET;
			count_mode_q       <= bdlpc_pkg::COUNT_MODE_RESET;
			active_high_q      <= bdlpc_pkg::ACTIVE_HIGH_RESET;
			raw_last_q         <= !bdlpc_pkg::ACTIVE_HIGH_RESET;
			quiet_timer_q      <= '0;
			steady_q           <= !bdlpc_pkg::ACTIVE_HIGH_RESET;
			hold_timer_q       <= '0;
			long_press_q       <= 1'b0;
			edge_counter_q     <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			if (in_fire) begin
				raw_last_q     <= pin_level;
				quiet_timer_q  <= quiet_timer_d;
				steady_q       <= steady_d;
				hold_timer_q   <= hold_timer_d;
				long_press_q   <= long_press_d;
				edge_counter_q <= edge_counter_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					bdlpc_pkg::REG_DEBOUNCE_TICKS: begin
						debounce_ticks_q <= cfg_data[bdlpc_pkg::SET_W-1:0];
					end
					bdlpc_pkg::REG_LONG_PRESS_TICKS: begin
						long_press_ticks_q <= cfg_data[bdlpc_pkg::SET_W-1:0];
					end
					bdlpc_pkg::REG_COUNT_MODE: begin
						count_mode_q <= cfg_data[bdlpc_pkg::MODE_W-1:0];
					end
					bdlpc_pkg::REG_ACTIVE_HIGH: begin
						active_high_q <= cfg_data[0];
						raw_last_q    <= !cfg_data[0];
						steady_q      <= !cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pressed_q        <= pressed_d;
			released_q       <= released_d;
			long_press_out_q <= long_press_d;
			edge_count_q     <= bdlpc_pkg::EDGE_COUNT_W'(edge_counter_d);
			stable_q         <= steady_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign pressed_event   = pressed_q;
	assign released_event  = released_q;
	assign long_press_flag = long_press_out_q;
	assign edge_count      = edge_count_q;
	assign stable_level    = stable_q;

endmodule

// ===== verif/bdlpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlpc_checker
// Watches the configuration, sample and result channels of the debouncer,
// keeps its own model of the debounce, long-press and edge counting state,
// and compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bdlpc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               pin_level,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               pressed_event,
	input  logic                               released_event,
	input  logic                               long_press_flag,
	input  logic [bdlpc_pkg::EDGE_COUNT_W-1:0] edge_count,
	input  logic                               stable_level,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [bdlpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bdlpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                 fail_count,
	output int                                 pending_results,
	output int                                 press_count,
	output int                                 long_press_count,
	output int                                 count_wraps
);

	typedef struct packed {
		logic                               pressed;
		logic                               released;
		logic                               long_press;
		logic [bdlpc_pkg::EDGE_COUNT_W-1:0] edges;
		logic                               level;
	} tick_result_t;

	localparam logic [bdlpc_pkg::TIMER_BITS_DEFAULT-1:0] TIMER_SAT = '1;

	logic [bdlpc_pkg::SET_W-1:0]              debounce_set;
	logic [bdlpc_pkg::SET_W-1:0]              long_set;
	logic [bdlpc_pkg::MODE_W-1:0]             mode_set;
	logic                                     act_high_set;
	logic                                     raw_seen;
	logic [bdlpc_pkg::TIMER_BITS_DEFAULT-1:0] quiet_cnt;
	logic                                     steady_lvl;
	logic [bdlpc_pkg::TIMER_BITS_DEFAULT-1:0] hold_cnt;
	logic                                     long_state;
	logic [bdlpc_pkg::EDGE_COUNT_W-1:0]       edge_total;

	tick_result_t predicted_ticks[$];

	function automatic tick_result_t debounce_tick(input logic pin);
		tick_result_t r;
		logic         was_steady;
		logic         bumped;
		r = '0;
		bumped = 1'b0;
		was_steady = steady_lvl;
		if (pin != raw_seen) begin
			raw_seen  = pin;
			quiet_cnt = '0;
		end else if (quiet_cnt != TIMER_SAT) begin
			quiet_cnt = quiet_cnt + 1'b1;
		end
		if (hold_cnt != TIMER_SAT)
			hold_cnt = hold_cnt + 1'b1;
		if (quiet_cnt > debounce_set)
			steady_lvl = pin;
		if (was_steady != steady_lvl) begin
			if (steady_lvl == act_high_set)
				r.pressed = 1'b1;
			else
				r.released = 1'b1;
			if (!steady_lvl) begin
				hold_cnt   = '0;
				long_state = 1'b0;
				if (mode_set[bdlpc_pkg::MODE_FALLING_BIT]) begin
					edge_total = edge_total + 1'b1;
					bumped     = 1'b1;
				end
			end else begin
				if (hold_cnt > long_set) begin
					if (!long_state)
						long_press_count++;
					long_state = 1'b1;
				end
				if (mode_set[bdlpc_pkg::MODE_RISING_BIT]) begin
					edge_total = edge_total + 1'b1;
					bumped     = 1'b1;
				end
			end
			if (bumped && (edge_total == '0))
				count_wraps++;
		end
		if (r.pressed)
			press_count++;
		r.long_press = long_state;
		r.edges      = edge_total;
		r.level      = steady_lvl;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tick_result_t want;
		tick_result_t got;
		if (!arst_n) begin
			debounce_set     = bdlpc_pkg::DEBOUNCE_RESET;
			long_set         = bdlpc_pkg::LONG_PRESS_RESET;
			mode_set         = bdlpc_pkg::COUNT_MODE_RESET;
			act_high_set     = bdlpc_pkg::ACTIVE_HIGH_RESET;
			raw_seen         = ~bdlpc_pkg::ACTIVE_HIGH_RESET;
			steady_lvl       = ~bdlpc_pkg::ACTIVE_HIGH_RESET;
			quiet_cnt        = '0;
			hold_cnt         = '0;
			long_state       = 1'b0;
			edge_total       = '0;
			fail_count       = 0;
			press_count      = 0;
			long_press_count = 0;
			count_wraps      = 0;
			predicted_ticks.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bdlpc_pkg::REG_DEBOUNCE_TICKS:
						debounce_set = cfg_data[bdlpc_pkg::SET_W-1:0];
					bdlpc_pkg::REG_LONG_PRESS_TICKS:
						long_set = cfg_data[bdlpc_pkg::SET_W-1:0];
					bdlpc_pkg::REG_COUNT_MODE:
						mode_set = cfg_data[bdlpc_pkg::MODE_W-1:0];
					bdlpc_pkg::REG_ACTIVE_HIGH: begin
						act_high_set = cfg_data[0];
						raw_seen     = ~cfg_data[0];
						steady_lvl   = ~cfg_data[0];
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predicted_ticks.push_back(debounce_tick(pin_level));
			if (out_valid && out_ready) begin
				got = {pressed_event, released_event, long_press_flag, edge_count,
					stable_level};
				if (predicted_ticks.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: result beat arrived with no sample outstanding", $realtime);
				end else begin
					want = predicted_ticks.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%t: mismatch, expected press %b release %b long %b count %0d level %b",
								$realtime, want.pressed, want.released, want.long_press,
								want.edges, want.level);
							$display("%t: mismatch,      got press %b release %b long %b count %0d level %b",
								$realtime, got.pressed, got.released, got.long_press,
								got.edges, got.level);
						end
					end
				end
			end
		end
		pending_results = predicted_ticks.size();
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the pushbutton debouncer with long-press detection.
// Drives bouncy press and release sequences under a range of register
// settings, including zero thresholds, both active levels and writes to
// unused register indexes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT   = 200_000;
	localparam int PHASE_TICKS   = 150;
	localparam int RANDOM_PHASES = 12;
	localparam logic [14:0] DIRECTED_PINS = 15'b110011000011101;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               in_valid  = 1'b0;
	logic                               pin_level = 1'b0;
	logic                               out_ready = 1'b0;
	logic                               cfg_valid = 1'b0;
	logic [bdlpc_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [bdlpc_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                               in_ready;
	logic                               out_valid;
	logic                               pressed_event;
	logic                               released_event;
	logic                               long_press_flag;
	logic [bdlpc_pkg::EDGE_COUNT_W-1:0] edge_count;
	logic                               stable_level;
	logic                               cfg_ready;

	int fail_count;
	int pending_results;
	int press_count;
	int long_press_count;
	int count_wraps;

	logic                        in_acc     = 1'b0;
	logic                        cfg_acc    = 1'b0;
	logic [1:0]                  stall_mode = 2'd0;
	int                          stall_left = 0;
	int                          burst_left = 0;
	int                          cycle_count = 0;
	int                          tick_total = 0;
	int                          phase_ticks = 0;
	int                          cfg_writes = 0;
	logic                        last_pin = 1'b1;
	logic [bdlpc_pkg::SET_W-1:0] cur_debounce = bdlpc_pkg::DEBOUNCE_RESET;
	logic [bdlpc_pkg::SET_W-1:0] cur_long = bdlpc_pkg::LONG_PRESS_RESET;

	button_debounce_longpress_counter u_dut (.*);
	bdlpc_checker u_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		in_acc  <= in_valid && in_ready;
		cfg_acc <= cfg_valid && cfg_ready;
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit.");
			$display("tb failed");
			$finish;
		end
	end

	// The receiver picks a new stall pattern at random whenever the current one runs out.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_left <= $urandom_range(10, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			2'd0:    out_ready <= 1'b1;
			2'd1:    out_ready <= 1'($urandom_range(0, 1));
			2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= stall_left[2];
		endcase
	end

	task automatic write_reg(input logic [bdlpc_pkg::CFG_INDEX_W-1:0] idx,
		input logic [bdlpc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (cfg_acc !== 1'b1);
		cfg_valid <= 1'b0;
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic send_pin(input logic pin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		pin_level <= pin;
		do @(negedge clk); while (in_acc !== 1'b1);
		last_pin = pin;
		tick_total++;
		phase_ticks++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic random_settings();
		logic [bdlpc_pkg::SET_W-1:0] d;
		logic [bdlpc_pkg::SET_W-1:0] l;
		case ($urandom_range(0, 7))
			0:       d = '0;
			1, 2:    d = bdlpc_pkg::SET_W'($urandom_range(1, 3));
			3, 4, 5: d = bdlpc_pkg::SET_W'($urandom_range(4, 12));
			6:       d = bdlpc_pkg::SET_W'($urandom_range(13, 40));
			default: d = bdlpc_pkg::SET_W'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 5))
			0:          l = '0;
			1, 2, 3:    l = bdlpc_pkg::SET_W'($urandom_range(1, 40));
			4:          l = bdlpc_pkg::SET_W'($urandom_range(0, 65535));
			default:    l = '1;
		endcase
		if ($urandom_range(0, 3) != 0) begin
			write_reg(bdlpc_pkg::REG_DEBOUNCE_TICKS, d);
			cur_debounce = d;
		end
		if ($urandom_range(0, 3) != 0) begin
			write_reg(bdlpc_pkg::REG_LONG_PRESS_TICKS, l);
			cur_long = l;
		end
		if ($urandom_range(0, 3) != 0)
			write_reg(bdlpc_pkg::REG_COUNT_MODE,
				bdlpc_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
		if ($urandom_range(0, 2) == 0)
			write_reg(bdlpc_pkg::REG_ACTIVE_HIGH,
				bdlpc_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
		if ($urandom_range(0, 3) == 0)
			write_reg(bdlpc_pkg::CFG_INDEX_W'($urandom_range(4, 255)),
				bdlpc_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
	endtask

	// A press or release with some contact bounce, or at times a run of random
	// samples, held for a time around the debounce and long-press settings.
	task automatic press_sequence();
		int   d_eff;
		int   l_eff;
		int   bounces;
		int   n;
		logic target;
		d_eff = (cur_debounce > 30) ? 30 : int'(cur_debounce);
		l_eff = (cur_long > 60) ? 60 : int'(cur_long);
		if ($urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 20);
			repeat (n) send_pin(1'($urandom_range(0, 1)));
		end else begin
			target = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : ~last_pin;
			bounces = $urandom_range(0, 4);
			for (int b = 0; b < bounces; b++) begin
				n = $urandom_range(1, d_eff + 1);
				repeat (n) send_pin((b % 2 == 0) ? target : ~target);
			end
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, d_eff + 1);
			else
				n = $urandom_range(d_eff + 2, d_eff + l_eff + 12);
			repeat (n) send_pin(target);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_pin(1'b0);
		send_pin(1'b0);
		send_pin(1'b0);
		send_pin(1'b1);
		send_pin(1'b1);
		wait_idle();

		write_reg(bdlpc_pkg::REG_DEBOUNCE_TICKS, '0);
		cur_debounce = '0;
		write_reg(bdlpc_pkg::REG_LONG_PRESS_TICKS, bdlpc_pkg::CFG_DATA_W'(3));
		cur_long = bdlpc_pkg::SET_W'(3);
		write_reg(bdlpc_pkg::REG_COUNT_MODE, bdlpc_pkg::CFG_DATA_W'(3));
		write_reg(bdlpc_pkg::REG_ACTIVE_HIGH, bdlpc_pkg::CFG_DATA_W'(1));
		write_reg('1, '1);
		for (int i = 14; i >= 0; i--)
			send_pin(DIRECTED_PINS[i]);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_settings();
			phase_ticks = 0;
			while (phase_ticks < PHASE_TICKS)
				press_sequence();
			wait_idle();
		end
		repeat (4) @(negedge clk);

		$display("Sent %0d sample ticks with %0d register writes.", tick_total, cfg_writes);
		$display("Saw %0d presses, %0d long presses and %0d counter wraps.",
			press_count, long_press_count, count_wraps);
		if (fail_count == 0 && pending_results == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
